/* hdl/stun_pkg.sv */
// Shared types, constants and the CRC-32 byte step for the STUN message parser.
// No dependencies; every module of the parser imports this package.
`timescale 1ns / 1ps
`default_nettype none
package stun_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [16:0] HDR_BYTES    = 17'd20;
  localparam logic [16:0] POS_MAX      = 17'h1FFFF;
  localparam logic [13:0] COUNT_MAX    = 14'h3FFF;
  localparam logic [31:0] STUN_MAGIC   = 32'h2112A442;
  localparam logic [31:0] FP_XOR       = 32'h5354554E;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
  localparam logic [7:0]  TOP_BITS     = 8'hC0;

  // record kind as carried on out_tuser
  localparam logic REC_ATTR    = 1'b0;
  localparam logic REC_VERDICT = 1'b1;

  // one queue entry: the records caused by one byte
  typedef struct packed {
    logic        attr_v;
    logic [15:0] atype;
    logic [15:0] alen;
    logic [16:0] aoff;
    logic [31:0] fp;
    logic        attr_last;
    logic        verd_v;
    logic [15:0] mtype;
    logic [15:0] mlen;
    logic        ok;
    logic [13:0] total;
  } stun_event_t;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/stun_front.sv */
// Front end: accepts datagram bytes, captures the header, tracks attribute
// boundaries and the running CRC, and forms one queue entry per reporting byte.
// Depends on stun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stun_front
  import stun_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_fire,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output stun_event_t      ev,
  output logic             ev_push
);

  logic [16:0] pos_r, pos_nxt;
  logic [15:0] htype_r, htype_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [31:0] cookie_r, cookie_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] crc_at_r, crc_at_nxt;
  logic [16:0] start_r, start_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [13:0] count_r, count_nxt;
  logic        fbad_r, fbad_nxt;

  logic [17:0] start_ext, end4, body_end, body_end_new, nlen, nsum;
  logic        in_hdr, attr_fire, ok;

  always_comb begin
    pos_nxt    = pos_r;
    htype_nxt  = htype_r;
    hlen_nxt   = hlen_r;
    cookie_nxt = cookie_r;
    crc_at_nxt = crc_at_r;
    start_nxt  = start_r;
    shift_nxt  = shift_r;
    count_nxt  = count_r;
    fbad_nxt   = fbad_r;
    attr_fire  = 1'b0;
    nlen       = '0;
    nsum       = '0;

    // header capture, big-endian
    if (pos_r == 17'd0) begin
      htype_nxt = {in_byte, 8'h00};
      fbad_nxt  = |(in_byte & TOP_BITS);
    end else if (pos_r == 17'd1) begin
      htype_nxt = {htype_r[15:8], in_byte};
    end else if (pos_r == 17'd2) begin
      hlen_nxt = {in_byte, 8'h00};
    end else if (pos_r == 17'd3) begin
      hlen_nxt = {hlen_r[15:8], in_byte};
    end else if (pos_r >= 17'd4 && pos_r < 17'd8) begin
      cookie_nxt = {cookie_r[23:0], in_byte};
    end

    start_ext = {1'b0, start_r};
    end4      = start_ext + 18'd4;
    body_end  = {1'b0, HDR_BYTES} + {2'b00, hlen_r};
    in_hdr    = (pos_r >= HDR_BYTES) && (pos_r >= start_r) &&
                ({1'b0, pos_r} < end4) && (end4 <= body_end);

    if (in_hdr) begin
      if (pos_r == start_r) crc_at_nxt = crc_r;
      shift_nxt = {shift_r[23:0], in_byte};
      if ({1'b0, pos_r} == start_ext + 18'd3) begin
        attr_fire = 1'b1;
        // value length rounded up to a whole word
        nlen      = ({2'b00, shift_r[7:0], in_byte} + 18'd3) & ~18'd3;
        nsum      = end4 + nlen;
        start_nxt = (nsum > {1'b0, POS_MAX}) ? POS_MAX : nsum[16:0];
        if (count_r < COUNT_MAX) count_nxt = count_r + 14'd1;
        shift_nxt = '0;
      end
    end

    crc_nxt = crc32_byte(crc_r, in_byte);
    if (pos_r < POS_MAX) pos_nxt = pos_r + 17'd1;

    body_end_new = {1'b0, HDR_BYTES} + {2'b00, hlen_nxt};
    ok = (pos_nxt >= HDR_BYTES) && !fbad_nxt && ({1'b0, pos_nxt} >= body_end_new) &&
         (cookie_nxt == STUN_MAGIC);

    ev.attr_v    = attr_fire;
    ev.atype     = shift_r[23:8];
    ev.alen      = {shift_r[7:0], in_byte};
    ev.aoff      = start_r;
    ev.fp        = ~crc_at_r ^ FP_XOR;
    ev.attr_last = !in_last;
    ev.verd_v    = in_last;
    ev.mtype     = htype_nxt;
    ev.mlen      = hlen_nxt;
    ev.ok        = ok;
    ev.total     = count_nxt;
    ev_push      = in_fire && (attr_fire || in_last);

    // end of datagram: back to the reset state
    if (in_last) begin
      pos_nxt    = '0;
      htype_nxt  = '0;
      hlen_nxt   = '0;
      cookie_nxt = '0;
      crc_nxt    = CRC_INIT;
      crc_at_nxt = '0;
      start_nxt  = HDR_BYTES;
      shift_nxt  = '0;
      count_nxt  = '0;
      fbad_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      htype_r  <= '0;
      hlen_r   <= '0;
      cookie_r <= '0;
      crc_r    <= CRC_INIT;
      crc_at_r <= '0;
      start_r  <= HDR_BYTES;
      shift_r  <= '0;
      count_r  <= '0;
      fbad_r   <= 1'b0;
    end else if (in_fire) begin
      pos_r    <= pos_nxt;
      htype_r  <= htype_nxt;
      hlen_r   <= hlen_nxt;
      cookie_r <= cookie_nxt;
      crc_r    <= crc_nxt;
      crc_at_r <= crc_at_nxt;
      start_r  <= start_nxt;
      shift_r  <= shift_nxt;
      count_r  <= count_nxt;
      fbad_r   <= fbad_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/stun_queue.sv */
// Short queue of record entries between the front and back ends, with a
// registered head entry. Depends on stun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stun_queue
  import stun_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire stun_event_t push_data,
  output logic             full,
  input  wire logic        pop,
  output stun_event_t      head,
  output logic             head_valid
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  stun_event_t   mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          head_v_r;
  stun_event_t   head_r;
  logic          do_read;

  assign full       = (cnt_r == CNT_FULL);
  assign do_read    = (cnt_r != '0) && (!head_v_r || pop);
  assign head       = head_r;
  assign head_valid = head_v_r;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
    if (do_read) head_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      head_v_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      if (do_read) rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      case ({push, do_read})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: cnt_r <= cnt_r;
      endcase
      if (do_read) head_v_r <= 1'b1;
      else if (pop) head_v_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hdl/stun_back.sv */
// Back end: takes queue entries and presents their attribute and verdict
// records on the output stream, attribute first. Depends on stun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stun_back
  import stun_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire stun_event_t   head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [127:0]       out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  stun_event_t ev_r;
  logic        attr_pend_r, verd_pend_r;
  logic        out_fire, done;

  assign out_tvalid = attr_pend_r || verd_pend_r;
  assign out_fire   = out_tvalid && out_tready;
  assign done       = out_fire && !(attr_pend_r && verd_pend_r);
  assign pop        = head_valid && (!out_tvalid || done);

  always_comb begin
    if (attr_pend_r) begin
      out_tuser = REC_ATTR;
      out_tlast = ev_r.attr_last;
      out_tdata = {47'd0, ev_r.fp, ev_r.aoff, ev_r.alen, ev_r.atype};
    end else begin
      out_tuser = REC_VERDICT;
      out_tlast = 1'b1;
      out_tdata = {ev_r.total, ev_r.ok, ev_r.mlen, ev_r.mtype, 81'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ev_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_pend_r <= 1'b0;
      verd_pend_r <= 1'b0;
    end else if (pop) begin
      attr_pend_r <= head.attr_v;
      verd_pend_r <= head.verd_v;
    end else if (out_fire) begin
      // drop the record just transferred
      if (attr_pend_r) attr_pend_r <= 1'b0;
      else verd_pend_r <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hdl/stun_message_parser.sv */
// Top level of the STUN message parser: front end, record queue, back end.
// Depends on stun_pkg, stun_front, stun_queue and stun_back.
//
// The parser takes one datagram byte per cycle on the in_ stream and never
// stalls the input while the output keeps up. Each byte that completes an
// attribute header inside the declared body yields an attribute record, and
// the byte marked tlast yields the verdict record; when both fall on one byte
// the back end sends both records from that entry, and a queue of Q_DEPTH
// entries absorbs this and short output stalls. A record reaches out_ through
// the queue entry, the queue head register and the output register.
`timescale 1ns / 1ps
`default_nettype none
module stun_message_parser
  import stun_pkg::*;
#(
  parameter int unsigned Q_DEPTH = QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [7:0]    in_tdata,   // [7:0] data_byte
  input  wire logic          in_tlast,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // [15:0] attribute_type, [31:16] attribute_length, [48:32] attribute_offset,
  // [80:49] fingerprint_value, [96:81] message_type, [112:97] message_length,
  // [113] header_ok, [127:114] attribute_total
  output logic [127:0]       out_tdata,
  output logic               out_tlast,
  output logic               out_tuser   // [0] record_kind
);

  stun_event_t ev, head;
  logic        ev_push, q_full, head_valid, pop, in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  stun_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .ev      (ev),
    .ev_push (ev_push)
  );

  stun_queue #(
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (ev_push),
    .push_data  (ev),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  stun_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire

/* hdl/stun_checker.sv */
// Port-level checks on the STUN message parser output stream, bound to the
// top level. Depends on the port list of stun_message_parser.
`timescale 1ns / 1ps
`default_nettype none
module stun_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [127:0] out_tdata,
  input wire logic         out_tlast,
  input wire logic         out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output record changed while stalled");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("verdict record without tlast");

  a_attr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[127:81] == 47'd0)
    else $error("attribute record carries verdict fields");

  a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[80:0] == 81'd0)
    else $error("verdict record carries attribute fields");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind stun_message_parser stun_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

/* test/stun_record_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the STUN message parser: predicts the records each byte causes
// and compares every out_ transfer with the oldest pending record. Uses stun_pkg.
module stun_record_checker
  import stun_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic         out_tlast,
  input  logic         out_tuser,
  output int           fail_count,
  output int           outstanding,
  output int           attr_records,
  output int           verdicts
);

  typedef struct packed {
    logic        kind;
    logic [15:0] atype;
    logic [15:0] alen;
    logic [16:0] aoff;
    logic [31:0] fp;
    logic [15:0] mtype;
    logic [15:0] mlen;
    logic        ok;
    logic [13:0] total;
    logic        fin;
  } stun_record_t;

  stun_record_t pending_records[$];

  int n_fail  = 0;
  int n_open  = 0;
  int n_attr_seen = 0;
  int n_verd_seen = 0;

  assign fail_count   = n_fail;
  assign outstanding  = n_open;
  assign attr_records = n_attr_seen;
  assign verdicts     = n_verd_seen;

  // parser state as seen from the byte stream
  int unsigned pos;
  int unsigned next_start;
  logic [15:0] hdr_type;
  logic [15:0] hdr_len;
  logic [31:0] cookie;
  logic [31:0] crc;
  logic [31:0] crc_mark;
  logic [31:0] hdr_shift;
  logic [13:0] attr_cnt;
  logic        bad_first;

  function automatic logic [31:0] crc_update(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic string fmt(input stun_record_t r);
    return $sformatf("kind %0d type %h len %h off %h fp %h mtype %h mlen %h ok %0d total %0d last %0d",
                     r.kind, r.atype, r.alen, r.aoff, r.fp, r.mtype, r.mlen, r.ok,
                     r.total, r.fin);
  endfunction

  task automatic clear_message();
    pos        = 0;
    next_start = 32'(HDR_BYTES);
    hdr_type   = '0;
    hdr_len    = '0;
    cookie     = '0;
    crc        = CRC_INIT;
    crc_mark   = '0;
    hdr_shift  = '0;
    attr_cnt   = '0;
    bad_first  = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin_byte);
    int unsigned p;
    int unsigned s;
    int unsigned nxt;
    logic ok;
    stun_record_t r;
    p = pos;
    s = next_start;
    if (p == 0) begin
      hdr_type  = {b, 8'h00};
      bad_first = |(b & TOP_BITS);
    end else if (p == 1) begin
      hdr_type[7:0] = b;
    end else if (p == 2) begin
      hdr_len = {b, 8'h00};
    end else if (p == 3) begin
      hdr_len[7:0] = b;
    end else if (p >= 4 && p < 8) begin
      cookie = {cookie[23:0], b};
    end

    // only attribute headers lying wholly inside the declared body count
    if (p >= 32'(HDR_BYTES) && p >= s && p < s + 32'd4 &&
        s + 32'd4 <= 32'(HDR_BYTES) + 32'(hdr_len)) begin
      if (p == s) crc_mark = crc;
      hdr_shift = {hdr_shift[23:0], b};
      if (p == s + 32'd3) begin
        r       = '0;
        r.kind  = REC_ATTR;
        r.atype = hdr_shift[31:16];
        r.alen  = hdr_shift[15:0];
        r.aoff  = s[16:0];
        r.fp    = ~crc_mark ^ FP_XOR;
        r.fin   = !fin_byte;
        pending_records.push_back(r);
        nxt = s + 32'd4 + ((32'(hdr_shift[15:0]) + 32'd3) & ~32'd3);
        next_start = (nxt > 32'(POS_MAX)) ? 32'(POS_MAX) : nxt;
        if (attr_cnt != COUNT_MAX) attr_cnt = attr_cnt + 1'b1;
        hdr_shift = '0;
      end
    end

    crc = crc_update(crc, b);
    if (pos < 32'(POS_MAX)) pos = pos + 1;

    if (fin_byte) begin
      ok = pos >= 32'(HDR_BYTES) && !bad_first &&
           pos >= 32'(HDR_BYTES) + 32'(hdr_len) && cookie == STUN_MAGIC;
      r       = '0;
      r.kind  = REC_VERDICT;
      r.mtype = hdr_type;
      r.mlen  = hdr_len;
      r.ok    = ok;
      r.total = attr_cnt;
      r.fin   = 1'b1;
      pending_records.push_back(r);
      clear_message();
    end
  endtask

  task automatic report_miss(input string what);
    n_fail++;
    if (n_fail <= 10) $display("%t checker: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    stun_record_t got;
    stun_record_t want;
    if (!rst_n) begin
      clear_message();
      pending_records.delete();
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        got.kind  = out_tuser;
        got.atype = out_tdata[15:0];
        got.alen  = out_tdata[31:16];
        got.aoff  = out_tdata[48:32];
        got.fp    = out_tdata[80:49];
        got.mtype = out_tdata[96:81];
        got.mlen  = out_tdata[112:97];
        got.ok    = out_tdata[113];
        got.total = out_tdata[127:114];
        got.fin   = out_tlast;
        if (pending_records.size() == 0) begin
          report_miss({"record with nothing pending: ", fmt(got)});
        end else begin
          want = pending_records.pop_front();
          if (got !== want)
            report_miss({"mismatch\n  expected ", fmt(want), "\n  actual   ", fmt(got)});
          if (want.kind == REC_VERDICT) n_verd_seen++;
          else n_attr_seen++;
        end
      end
    end
    n_open <= pending_records.size();
  end

endmodule

/* test/tb_stun_message_parser.sv */
`timescale 1ns / 1ps
// Top of the STUN parser testbench: builds datagrams, drives the byte stream,
// throttles the record stream and gives the verdict. Needs stun_pkg, the RTL
// and stun_record_checker.
module tb_stun_message_parser;
  import stun_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_BYTES = 280;
  localparam int CALM_BYTES   = 100;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic [7:0]   in_tdata   = 8'h00;
  logic         in_tlast   = 1'b0;
  logic         out_tready = 1'b0;
  logic         quiet      = 1'b0;
  logic         src_busy   = 1'b0;
  logic         sink_busy  = 1'b0;
  int           sink_hold  = 0;
  int           idle_cycles = 0;
  int           frames     = 0;
  int           bytes_sent = 0;

  wire          in_tready;
  wire          out_tvalid;
  wire [127:0]  out_tdata;
  wire          out_tlast;
  wire          out_tuser;
  int           fail_count;
  int           outstanding;
  int           attr_records;
  int           verdicts;

  logic [7:0]   frame_q[$];

  always #10 clk = ~clk;

  stun_message_parser uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  stun_record_checker records (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .attr_records (attr_records),
    .verdicts     (verdicts)
  );

  // record sink: random stall bursts, switched on and off in stretches
  always @(posedge clk) begin
    if ($urandom_range(0, 39) == 0) sink_busy <= !sink_busy;
    if (!quiet && sink_busy && sink_hold == 0 && $urandom_range(0, 4) == 0) begin
      sink_hold  <= $urandom_range(1, 4);
      out_tready <= 1'b0;
    end else if (sink_hold > 1) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      sink_hold  <= 0;
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_stun_message_parser: timeout after %0d idle cycles", idle_cycles);
      $display("tb_stun_message_parser: done, errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic fin_byte);
    if ($urandom_range(0, 29) == 0) src_busy = !src_busy;
    if (!quiet && src_busy && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin_byte;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i], i == frame_q.size() - 1);
    frames++;
  endtask

  task automatic put_be(input logic [31:0] v, input int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) frame_q.push_back(v[8*i +: 8]);
  endtask

  // header with a random transaction id
  task automatic add_header(input logic [15:0] mtype, input logic [15:0] mlen,
                            input logic [31:0] magic);
    put_be(mtype, 2);
    put_be(mlen, 2);
    put_be(magic, 4);
    repeat (12) frame_q.push_back(8'($urandom));
  endtask

  // attribute header plus random value padded to 4 bytes
  task automatic add_attr(input logic [15:0] atype, input logic [15:0] alen);
    put_be(atype, 2);
    put_be(alen, 2);
    repeat ((32'(alen) + 3) & ~32'd3) frame_q.push_back(8'($urandom));
  endtask

  // mostly well-formed messages; the rest truncated, mislabeled, corrupted or noise
  task automatic build_random_frame();
    int flavor;
    int cut;
    int idx;
    logic [15:0] body;
    frame_q.delete();
    flavor = $urandom_range(0, 9);
    if (flavor == 9) begin
      repeat ($urandom_range(1, 30)) frame_q.push_back(8'($urandom));
      return;
    end
    add_header({2'b00, 14'($urandom_range(0, 16383))}, 16'h0000, STUN_MAGIC);
    repeat ($urandom_range(0, 3)) add_attr(16'($urandom), 16'($urandom_range(0, 9)));
    body = 16'(frame_q.size() - 20);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    case (flavor)
      6: begin
        cut = $urandom_range(1, frame_q.size() - 1);
        while (frame_q.size() > cut) void'(frame_q.pop_back());
      end
      7: begin
        if ($urandom_range(0, 1) == 0) body = 16'($urandom);
        else body = body - 16'($urandom_range(1, 3));
      end
      8: begin
        idx = $urandom_range(0, 7);
        frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      default: ;
    endcase
    if (frame_q.size() >= 4) begin
      frame_q[2] = body[15:8];
      frame_q[3] = body[7:0];
    end
  endtask

  initial begin
    int calm_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // short datagram with both top bits set
    frame_q = '{8'hFF};
    send_frame();
    // attribute header completed by the last byte: attribute record, then verdict
    frame_q.delete();
    add_header(16'h0001, 16'h0004, STUN_MAGIC);
    add_attr(16'hFFFF, 16'h0000);
    send_frame();

    while (bytes_sent < RANDOM_BYTES) begin
      build_random_frame();
      send_frame();
    end

    quiet <= 1'b1;
    calm_start = bytes_sent;
    while (bytes_sent < calm_start + CALM_BYTES) begin
      build_random_frame();
      send_frame();
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("tb_stun_message_parser: %0d datagrams, %0d bytes in", frames, bytes_sent);
    $display("tb_stun_message_parser: %0d attribute and %0d verdict records over short, %s",
             attr_records, verdicts, "truncated, mislabeled, corrupted and noise datagrams");
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_stun_message_parser: done, clean");
    end else begin
      $display("tb_stun_message_parser: done, errors");
    end
    $finish;
  end

endmodule
